[rtl/lvm_pkg.sv]
// Shared types, constants and rounding helpers for the look-at view matrix block.
// No dependencies; imported by lvm_norm and lookat_view_matrix_top.
`timescale 1ns / 1ps
package lvm_pkg;

  // width of a vector component entering the normaliser
  localparam int NORM_W = 36;
  // sideband carried alongside each normaliser item: two 32-bit triples, Q16.16 eye plus Q16.16 up or Q2.30 forward
  localparam int SIDE_W = 192;

  // wide working type for products and sums
  typedef logic signed [71:0] wide_t;

  // three Q2.30 components, x in the lowest slot
  typedef logic [2:0][31:0] vec_t;

  localparam wide_t ONE_Q30     = 72'sd1073741824;
  localparam wide_t TRANS_LIMIT = 72'sd3719550787;
  localparam wide_t HALF_Q30    = 72'sd536870912;

  // right shift by 30, magnitude rounded half away from zero
  function automatic wide_t rsh30(input wide_t v);
    wide_t m;
    m = (v < 0) ? -v : v;
    m = (m + HALF_Q30) >>> 30;
    return (v < 0) ? -m : m;
  endfunction

  // symmetric saturation to +-lim
  function automatic wide_t clampv(input wide_t v, input wide_t lim);
    wide_t r;
    r = v;
    if (v > lim) r = lim;
    if (v < -lim) r = -lim;
    return r;
  endfunction

endpackage

[rtl/lvm_norm.sv]
// Pipelined vector normaliser: scale, sum of squares, bitwise square root,
// then three bitwise dividers. Depends on lvm_pkg.
`timescale 1ns / 1ps
module lvm_norm #(
  parameter int VW = lvm_pkg::NORM_W,
  parameter int SW = lvm_pkg::SIDE_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [2:0][VW-1:0]  vin,       // signed components
  input  logic [SW-1:0]       side_in,
  output logic                out_valid,
  output lvm_pkg::vec_t       vout,
  output logic [SW-1:0]       side_out
);
  import lvm_pkg::*;

  localparam int SQ  = 32;               // root bits, one per stage
  localparam int DV  = 31;               // quotient bits, one per stage
  localparam int DI  = 4 + SQ;           // stage index of divider set-up
  localparam int LAT = DI + DV + 2;      // total stages
  localparam int MW  = $clog2(VW);

  logic [LAT-1:0]          vld;
  logic [LAT-1:0][SW-1:0]  side;
  logic [LAT-1:0]          zero;
  logic [LAT-1:0][2:0]     neg;
  logic [DI-1:1][2:0][30:0] mn;

  // stage A: magnitudes
  logic [2:0][VW-1:0] ma;
  logic [VW-1:0]      or_a;
  // stage B: scaled magnitudes
  logic [MW-1:0]      msb;
  logic [2:0][30:0]   mn_b;
  logic [VW-1:0]      sh_tmp [3];
  // stage C/D: squares and their sum
  logic [2:0][61:0]   sq_c;
  // square root stages, index 0 is the sum register
  logic [63:0] rt_s    [SQ+1];
  logic [35:0] rt_rem  [SQ+1];
  logic [31:0] rt_root [SQ+1];
  logic [63:0] rt_s_next    [SQ+1];
  logic [35:0] rt_rem_next  [SQ+1];
  logic [31:0] rt_root_next [SQ+1];
  // divider stages, index 0 is the set-up register
  logic [31:0]      dv_n    [DV+1];
  logic [2:0][32:0] dv_rem  [DV+1];
  logic [2:0][30:0] dv_low  [DV+1];
  logic [2:0][30:0] dv_q    [DV+1];
  logic [2:0][32:0] dv_rem_next [DV+1];
  logic [2:0][30:0] dv_low_next [DV+1];
  logic [2:0][30:0] dv_q_next   [DV+1];
  logic [61:0]      num [3];
  logic [35:0]      r4w;
  logic [35:0]      trial;
  logic [33:0]      r2;
  vec_t             res;

  // valid bits reset, payload does not
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // leading one of the largest magnitude and scaling to bit 30
  always_comb begin
    msb = '0;
    for (int b = 0; b < VW; b++) begin
      if (or_a[b]) msb = MW'(b);
    end
    for (int i = 0; i < 3; i++) begin
      if (msb >= MW'(30)) sh_tmp[i] = ma[i] >> (msb - MW'(30));
      else sh_tmp[i] = ma[i] << (MW'(30) - msb);
      mn_b[i] = sh_tmp[i][30:0];
    end
  end

  // one root bit per stage, two radicand bits brought down each time
  always_comb begin
    r4w = '0;
    trial = '0;
    rt_s_next[0] = '0;
    rt_rem_next[0] = '0;
    rt_root_next[0] = '0;
    for (int k = 1; k <= SQ; k++) begin
      r4w = {rt_rem[k-1][33:0], rt_s[k-1][63:62]};
      trial = {2'b00, rt_root[k-1], 2'b01};
      rt_s_next[k] = rt_s[k-1] << 2;
      if (r4w >= trial) begin
        rt_rem_next[k] = r4w - trial;
        rt_root_next[k] = {rt_root[k-1][30:0], 1'b1};
      end else begin
        rt_rem_next[k] = r4w;
        rt_root_next[k] = {rt_root[k-1][30:0], 1'b0};
      end
    end
  end

  // rounded numerator (m << 30) + n/2 for each lane
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = {1'b0, mn[DI-1][i], 30'b0} + 62'(rt_root[SQ][31:1]);
    end
  end

  // one quotient bit per stage per lane
  always_comb begin
    r2 = '0;
    dv_rem_next[0] = '0;
    dv_low_next[0] = '0;
    dv_q_next[0] = '0;
    for (int k = 1; k <= DV; k++) begin
      for (int i = 0; i < 3; i++) begin
        r2 = {dv_rem[k-1][i], dv_low[k-1][i][30]};
        dv_low_next[k][i] = dv_low[k-1][i] << 1;
        if (r2 >= {2'b00, dv_n[k-1]}) begin
          dv_rem_next[k][i] = 33'(r2 - {2'b00, dv_n[k-1]});
          dv_q_next[k][i] = {dv_q[k-1][i][29:0], 1'b1};
        end else begin
          dv_rem_next[k][i] = r2[32:0];
          dv_q_next[k][i] = {dv_q[k-1][i][29:0], 1'b0};
        end
      end
    end
  end

  // sign restore, zero vector gives zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (zero[LAT-2]) res[i] = '0;
      else if (neg[LAT-2][i]) res[i] = -{1'b0, dv_q[DV][i]};
      else res[i] = {1'b0, dv_q[DV][i]};
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side_in;
      zero[0] <= (vin[0] == '0) && (vin[1] == '0) && (vin[2] == '0);
      for (int i = 0; i < 3; i++) begin
        neg[0][i] <= vin[i][VW-1];
        ma[i] <= vin[i][VW-1] ? -vin[i] : vin[i];
      end
      or_a <= (vin[0][VW-1] ? -vin[0] : vin[0]) | (vin[1][VW-1] ? -vin[1] : vin[1])
            | (vin[2][VW-1] ? -vin[2] : vin[2]);
      for (int s = 1; s < LAT; s++) begin
        side[s] <= side[s-1];
        zero[s] <= zero[s-1];
        neg[s] <= neg[s-1];
      end
      mn[1] <= mn_b;
      for (int s = 2; s <= DI-1; s++) begin
        mn[s] <= mn[s-1];
      end
      for (int i = 0; i < 3; i++) begin
        sq_c[i] <= 62'(mn[1][i]) * 62'(mn[1][i]);
      end
      rt_s[0] <= 64'(sq_c[0]) + 64'(sq_c[1]) + 64'(sq_c[2]);
      rt_rem[0] <= '0;
      rt_root[0] <= '0;
      for (int k = 1; k <= SQ; k++) begin
        rt_s[k] <= rt_s_next[k];
        rt_rem[k] <= rt_rem_next[k];
        rt_root[k] <= rt_root_next[k];
      end
      dv_n[0] <= rt_root[SQ];
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= {2'b00, num[i][61:31]};
        dv_low[0][i] <= num[i][30:0];
        dv_q[0][i] <= '0;
      end
      for (int k = 1; k <= DV; k++) begin
        dv_n[k] <= dv_n[k-1];
        dv_rem[k] <= dv_rem_next[k];
        dv_low[k] <= dv_low_next[k];
        dv_q[k] <= dv_q_next[k];
      end
      vout <= res;
    end
  end

  assign out_valid = vld[LAT-1];
  assign side_out  = side[LAT-1];

endmodule

[rtl/lookat_view_matrix_top.sv]
// Look-at view matrix: forward, up and right axes plus translations.
// An item passes through 147 register stages from the input to the output register;
// one item per cycle sustained while the output is not stalled, set by the
// fully pipelined square root and dividers in the two lvm_norm units (69 stages each).
// The whole pipeline advances together whenever the output register is empty or taken.
// Reset (rst, synchronous) clears all valid bits; no item is in flight afterwards.
// Depends on lvm_pkg and lvm_norm.
`timescale 1ns / 1ps
module lookat_view_matrix_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, upvec_x, upvec_y, upvec_z
  input  logic [287:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // right_x/y/z, upaxis_x/y/z, fwd_x/y/z (32 each), trans_x/y/z (33 each), 5 pad bits
  output logic [391:0] m_tdata
);
  import lvm_pkg::*;

  logic en;

  // input stage
  logic               t1_vld;
  logic signed [31:0] t1_eye [3];
  logic signed [31:0] t1_up  [3];
  logic [2:0][NORM_W-1:0] t1_d;

  // first normaliser
  logic              n1_vld;
  vec_t              n1_fz;
  logic [SIDE_W-1:0] n1_side;
  logic [SIDE_W-1:0] n1_side_in;

  // projection of up on forward
  logic               m1_vld, m2_vld, m3_vld, m4_vld;
  logic signed [31:0] m1_eye [3], m2_eye [3], m3_eye [3], m4_eye [3];
  logic signed [31:0] m1_fz [3], m2_fz [3], m3_fz [3], m4_fz [3];
  logic signed [31:0] m1_up [3], m2_up [3], m3_up [3];
  logic signed [63:0] m1_pr [3];
  logic signed [34:0] m2_p;
  logic signed [66:0] m3_fp [3];
  logic [2:0][NORM_W-1:0] m4_w;
  wide_t              p_sum;

  // second normaliser
  logic              n2_vld;
  vec_t              n2_uy;
  logic [SIDE_W-1:0] n2_side;
  logic [SIDE_W-1:0] n2_side_in;
  logic signed [31:0] n2_eye [3];
  logic signed [31:0] n2_fz  [3];

  // cross product and translations
  logic               c1_vld, c2_vld, c3_vld, c4_vld;
  logic signed [63:0] c1_cx [6];
  logic signed [63:0] c1_ey [3];
  logic signed [63:0] c1_ez [3];
  logic signed [31:0] c1_eye [3], c2_eye [3];
  logic signed [31:0] c1_uy [3], c2_uy [3], c3_uy [3], c4_uy [3];
  logic signed [31:0] c1_fz [3], c2_fz [3], c3_fz [3], c4_fz [3];
  logic signed [31:0] c2_rx [3], c3_rx [3], c4_rx [3];
  logic signed [32:0] c2_ty, c2_tz, c3_ty, c3_tz, c4_ty, c4_tz, c4_tx;
  logic signed [63:0] c3_xp [3];
  wide_t              rx_w [3];
  wide_t              ty_w, tz_w, tx_w;

  // single pipeline advance
  assign en       = ~m_tvalid | m_tready;
  assign s_tready = en;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      t1_vld <= 1'b0;
      m1_vld <= 1'b0;
      m2_vld <= 1'b0;
      m3_vld <= 1'b0;
      m4_vld <= 1'b0;
      c1_vld <= 1'b0;
      c2_vld <= 1'b0;
      c3_vld <= 1'b0;
      c4_vld <= 1'b0;
    end else if (en) begin
      t1_vld <= s_tvalid;
      m1_vld <= n1_vld;
      m2_vld <= m1_vld;
      m3_vld <= m2_vld;
      m4_vld <= m3_vld;
      c1_vld <= n2_vld;
      c2_vld <= c1_vld;
      c3_vld <= c2_vld;
      c4_vld <= c3_vld;
    end
  end

  // input capture and eye-to-target difference
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t1_eye[i] <= $signed(s_tdata[32*i +: 32]);
        t1_up[i]  <= $signed(s_tdata[192 + 32*i +: 32]);
        t1_d[i]   <= NORM_W'($signed(s_tdata[96 + 32*i +: 32]))
                   - NORM_W'($signed(s_tdata[32*i +: 32]));
      end
    end
  end

  assign n1_side_in = {t1_up[2], t1_up[1], t1_up[0], t1_eye[2], t1_eye[1], t1_eye[0]};

  lvm_norm #(.VW(NORM_W), .SW(SIDE_W)) u_norm_fwd (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (t1_vld),
    .vin       (t1_d),
    .side_in   (n1_side_in),
    .out_valid (n1_vld),
    .vout      (n1_fz),
    .side_out  (n1_side)
  );

  // p = fwd . up, then w = up - fwd * p
  always_comb begin
    p_sum = wide_t'(m1_pr[0]) + wide_t'(m1_pr[1]) + wide_t'(m1_pr[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m1_eye[i] <= $signed(n1_side[32*i +: 32]);
        m1_up[i]  <= $signed(n1_side[96 + 32*i +: 32]);
        m1_fz[i]  <= $signed(n1_fz[i]);
        m1_pr[i]  <= $signed(n1_fz[i]) * $signed(n1_side[96 + 32*i +: 32]);
        m2_eye[i] <= m1_eye[i];
        m2_up[i]  <= m1_up[i];
        m2_fz[i]  <= m1_fz[i];
        m3_eye[i] <= m2_eye[i];
        m3_up[i]  <= m2_up[i];
        m3_fz[i]  <= m2_fz[i];
        m3_fp[i]  <= 67'(m2_fz[i]) * 67'(m2_p);
        m4_eye[i] <= m3_eye[i];
        m4_fz[i]  <= m3_fz[i];
        m4_w[i]   <= NORM_W'(wide_t'(m3_up[i]) - rsh30(wide_t'(m3_fp[i])));
      end
      m2_p <= 35'(rsh30(p_sum));
    end
  end

  assign n2_side_in = {m4_fz[2], m4_fz[1], m4_fz[0], m4_eye[2], m4_eye[1], m4_eye[0]};

  lvm_norm #(.VW(NORM_W), .SW(SIDE_W)) u_norm_up (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (m4_vld),
    .vin       (m4_w),
    .side_in   (n2_side_in),
    .out_valid (n2_vld),
    .vout      (n2_uy),
    .side_out  (n2_side)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n2_eye[i] = $signed(n2_side[32*i +: 32]);
      n2_fz[i]  = $signed(n2_side[96 + 32*i +: 32]);
    end
  end

  // combine products into right axis and translations
  always_comb begin
    rx_w[0] = clampv(rsh30(wide_t'(c1_cx[0]) - wide_t'(c1_cx[1])), ONE_Q30);
    rx_w[1] = clampv(rsh30(wide_t'(c1_cx[2]) - wide_t'(c1_cx[3])), ONE_Q30);
    rx_w[2] = clampv(rsh30(wide_t'(c1_cx[4]) - wide_t'(c1_cx[5])), ONE_Q30);
    ty_w = clampv(-rsh30(wide_t'(c1_ey[0]) + wide_t'(c1_ey[1]) + wide_t'(c1_ey[2])),
                  TRANS_LIMIT);
    tz_w = clampv(-rsh30(wide_t'(c1_ez[0]) + wide_t'(c1_ez[1]) + wide_t'(c1_ez[2])),
                  TRANS_LIMIT);
    tx_w = clampv(-rsh30(wide_t'(c3_xp[0]) + wide_t'(c3_xp[1]) + wide_t'(c3_xp[2])),
                  TRANS_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // cross(upaxis, fwd) terms and dot products with eye
      c1_cx[0] <= $signed(n2_uy[1]) * n2_fz[2];
      c1_cx[1] <= $signed(n2_uy[2]) * n2_fz[1];
      c1_cx[2] <= $signed(n2_uy[2]) * n2_fz[0];
      c1_cx[3] <= $signed(n2_uy[0]) * n2_fz[2];
      c1_cx[4] <= $signed(n2_uy[0]) * n2_fz[1];
      c1_cx[5] <= $signed(n2_uy[1]) * n2_fz[0];
      for (int i = 0; i < 3; i++) begin
        c1_ey[i]  <= $signed(n2_uy[i]) * n2_eye[i];
        c1_ez[i]  <= n2_fz[i] * n2_eye[i];
        c1_eye[i] <= n2_eye[i];
        c1_uy[i]  <= $signed(n2_uy[i]);
        c1_fz[i]  <= n2_fz[i];
        c2_eye[i] <= c1_eye[i];
        c2_uy[i]  <= c1_uy[i];
        c2_fz[i]  <= c1_fz[i];
        c2_rx[i]  <= 32'(rx_w[i]);
        c3_uy[i]  <= c2_uy[i];
        c3_fz[i]  <= c2_fz[i];
        c3_rx[i]  <= c2_rx[i];
        c3_xp[i]  <= c2_rx[i] * c2_eye[i];
        c4_uy[i]  <= c3_uy[i];
        c4_fz[i]  <= c3_fz[i];
        c4_rx[i]  <= c3_rx[i];
      end
      c2_ty <= 33'(ty_w);
      c2_tz <= 33'(tz_w);
      c3_ty <= c2_ty;
      c3_tz <= c2_tz;
      c4_ty <= c3_ty;
      c4_tz <= c3_tz;
      c4_tx <= 33'(tx_w);
    end
  end

  // output register fields
  assign m_tvalid = c4_vld;
  assign m_tdata  = {5'b0, c4_tz, c4_ty, c4_tx,
                     c4_fz[2], c4_fz[1], c4_fz[0],
                     c4_uy[2], c4_uy[1], c4_uy[0],
                     c4_rx[2], c4_rx[1], c4_rx[0]};

endmodule

[bench/tb_top.sv]
// Self-checking bench for lookat_view_matrix_top: random camera poses in, view matrices out.
// Depends on lvm_pkg and the RTL of lookat_view_matrix_top; nothing else.
`timescale 1ns / 1ps
module tb_top;
  import lvm_pkg::*;

  typedef struct packed {
    logic [32:0] tz, ty, tx;
    logic [2:0][31:0] fwd, upa, rgt;
  } view_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [287:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [391:0] m_tdata;

  int  cycles = 0;
  bit  no_idle = 1'b0;
  int  hold_off = 0;

  always #2 clk = ~clk;

  lookat_view_matrix_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // rounding right shift: magnitude rounded half away from zero
  function automatic longint rnd_shift(longint v, int s);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint sat(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // unit vector in Q2.30; zero vector stays zero
  function automatic void unit_vec(input longint v[3], output longint o[3]);
    longint unsigned m[3], mx, s, n, q;
    mx = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (v[i] < 0) ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
      return;
    end
    while (mx >= (64'd1 << 31)) begin
      for (int i = 0; i < 3; i++) m[i] >>= 1;
      mx >>= 1;
    end
    while (mx < (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] <<= 1;
      mx <<= 1;
    end
    for (int i = 0; i < 3; i++) s += m[i] * m[i];
    n = int_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 30) + (n >> 1)) / n;
      o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic longint dot30(longint a[3], longint b[3]);
    return rnd_shift(a[0] * b[0] + a[1] * b[1] + a[2] * b[2], 30);
  endfunction

  // full view matrix for one pose
  function automatic view_t view_of(logic [287:0] p);
    longint eye[3], d[3], up[3], w[3], fz[3], uy[3], rx[3];
    longint pr;
    view_t r;
    for (int i = 0; i < 3; i++) begin
      eye[i] = longint'($signed(p[32*i +: 32]));
      d[i]   = longint'($signed(p[32*(3+i) +: 32])) - eye[i];
      up[i]  = longint'($signed(p[32*(6+i) +: 32]));
    end
    unit_vec(d, fz);
    pr = dot30(fz, up);
    for (int i = 0; i < 3; i++) w[i] = up[i] - rnd_shift(fz[i] * pr, 30);
    unit_vec(w, uy);
    rx[0] = uy[1] * fz[2] - uy[2] * fz[1];
    rx[1] = uy[2] * fz[0] - uy[0] * fz[2];
    rx[2] = uy[0] * fz[1] - uy[1] * fz[0];
    for (int i = 0; i < 3; i++) begin
      rx[i] = sat(rnd_shift(rx[i], 30), 64'sd1073741824);
      r.rgt[i] = rx[i][31:0];
      r.upa[i] = uy[i][31:0];
      r.fwd[i] = fz[i][31:0];
    end
    r.tx = 33'(sat(-dot30(rx, eye), 64'sd3719550787));
    r.ty = 33'(sat(-dot30(uy, eye), 64'sd3719550787));
    r.tz = 33'(sat(-dot30(fz, eye), 64'sd3719550787));
    return r;
  endfunction

  class view_board;
    view_t pending[$];
    int    errors = 0;
    int    poses = 0;
    int    matrices = 0;

    function void note_pose(logic [287:0] p);
      pending.push_back(view_of(p));
      poses++;
    endfunction

    function void check_matrix(logic [391:0] d);
      view_t got, exp_v;
      got = d[386:0];
      matrices++;
      if (pending.size() == 0) begin
        $display("%0t unexpected matrix %h", $realtime, d);
        errors++;
        return;
      end
      exp_v = pending.pop_front();
      for (int i = 0; i < 3; i++) begin
        if (got.rgt[i] !== exp_v.rgt[i]) begin
          $display("%0t right[%0d] exp %h got %h", $realtime, i, exp_v.rgt[i], got.rgt[i]);
          errors++;
        end
        if (got.upa[i] !== exp_v.upa[i]) begin
          $display("%0t upaxis[%0d] exp %h got %h", $realtime, i, exp_v.upa[i], got.upa[i]);
          errors++;
        end
        if (got.fwd[i] !== exp_v.fwd[i]) begin
          $display("%0t fwd[%0d] exp %h got %h", $realtime, i, exp_v.fwd[i], got.fwd[i]);
          errors++;
        end
      end
      if (got.tx !== exp_v.tx) begin
        $display("%0t trans_x exp %h got %h", $realtime, exp_v.tx, got.tx);
        errors++;
      end
      if (got.ty !== exp_v.ty) begin
        $display("%0t trans_y exp %h got %h", $realtime, exp_v.ty, got.ty);
        errors++;
      end
      if (got.tz !== exp_v.tz) begin
        $display("%0t trans_z exp %h got %h", $realtime, exp_v.tz, got.tz);
        errors++;
      end
    endfunction
  endclass

  view_board board = new();

  // random Q16.16 value: full range, small, or an extreme
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3: return $urandom_range(0, 2) - 1;
      4, 5: return 32'($signed($urandom_range(0, 20'hFFFFF)) - 20'sd524288);
      default: return $urandom;
    endcase
  endfunction

  // offer one pose with optional leading gap, wait for its acceptance;
  // valid stays high afterwards so the next pose can follow straight on
  task automatic send_pose(logic [287:0] p);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= p;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_pose(p);
  endtask

  task automatic send_triples(logic [31:0] e[3], logic [31:0] t[3], logic [31:0] u[3]);
    send_pose({u[2], u[1], u[0], t[2], t[1], t[0], e[2], e[1], e[0]});
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // receiver: random stall bursts, plus a requested long hold-off
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off > 0) begin
        m_tready <= 1'b0;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
        if (m_tvalid && m_tready) board.check_matrix(m_tdata);
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL lookat_view_matrix_top");
      $finish;
    end
  end

  initial begin
    logic [31:0] e[3], t[3], u[3];
    logic [287:0] p;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: degenerate and extreme poses
    e = '{0, 0, 0}; t = '{0, 0, 0}; u = '{0, 32'h10000, 0};
    send_triples(e, t, u);                               // eye equals target
    t = '{0, 0, 32'hFFFF_0000};
    send_triples(e, t, u);                               // classic look down -z
    u = '{0, 0, 32'h10000};
    send_triples(e, t, u);                               // up parallel to forward
    u = '{0, 0, 0};
    send_triples(e, t, u);                               // zero up
    t = '{0, 0, 1};
    u = '{1, 0, 0};
    send_triples(e, t, u);                               // tiny vectors
    e = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    t = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    u = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    send_triples(e, t, u);                               // widest span
    send_triples(t, e, u);
    e = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    t = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    u = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    send_triples(e, t, u);
    send_triples(t, t, u);
    e = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
    t = '{32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0000};
    u = '{0, 32'h7FFF_FFFF, 0};
    send_triples(e, t, u);                               // large eye, big translation
    send_pose('1);
    send_pose('0);
    for (int i = 0; i < 6; i++) begin
      for (int k = 0; k < 9; k++) p[32*k +: 32] = $urandom;
      send_pose(p);
    end

    // sender pauses until everything has drained
    wait_drained();

    // long receiver hold-off while poses keep coming
    hold_off = 400;
    for (int i = 0; i < 300; i++) begin
      for (int k = 0; k < 9; k++) p[32*k +: 32] = $urandom;
      send_pose(p);
    end

    for (int i = 0; i < 1300; i++) begin
      if (i == 1050) no_idle = 1'b1;
      for (int k = 0; k < 9; k++) p[32*k +: 32] = rand_coord();
      if ($urandom_range(0, 15) == 0) p[32*3 +: 96] = p[0 +: 96];   // eye on target
      if ($urandom_range(0, 15) == 0) p[32*6 +: 96] = p[32*3 +: 96]; // up along target
      send_pose(p);
    end

    wait_drained();
    repeat (200) @(posedge clk);
    $display("Covered %0d poses and %0d matrices, with degenerate axes and extremes.",
             board.poses, board.matrices);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("PASS lookat_view_matrix_top");
    else
      $display("FAIL lookat_view_matrix_top");
    $finish;
  end
endmodule
